@@ rtl/sfla_pkg.sv @@
// ----------------------------------------------------------------------------
// Slab free-list allocator package
// Shared widths, codes and the result record for the allocator core and its
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sfla_pkg;

  // pool geometry
  localparam int unsigned NUM_SLOTS      = 1024;
  localparam int unsigned SLOTS_PER_SLAB = 1;
  localparam int unsigned MAX_SLABS      = NUM_SLOTS / SLOTS_PER_SLAB;

  // field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned SLAB_W = 11;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned CIDX_W = 1;

  // slab count saturates at the pool limit or at the field maximum
  localparam int unsigned SLAB_MAXVAL = (1 << SLAB_W) - 1;
  localparam int unsigned SLAB_CAP    = (MAX_SLABS < SLAB_MAXVAL) ? MAX_SLABS : SLAB_MAXVAL;
  localparam logic [SLAB_W-1:0] SLAB_LIMIT = SLAB_W'(SLAB_CAP);

  // slot-within-slab counter
  localparam int unsigned K_W = (SLOTS_PER_SLAB > 1) ? $clog2(SLOTS_PER_SLAB) : 1;
  localparam logic [K_W-1:0] K_LAST = K_W'(SLOTS_PER_SLAB - 1);

  // wide enough for slab_count * SLOTS_PER_SLAB and for NUM_SLOTS
  localparam int unsigned EXT_W = SLAB_W + 7;

  // operations
  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_INITIAL_SLABS = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_VALIDATE      = 1'd1;

  localparam logic [CFG_W-1:0] INITIAL_SLABS_RST = CFG_W'(1024);

  typedef struct packed {
    logic [SLOT_W-1:0] granted;
    logic [STAT_W-1:0] status;
    logic [SLAB_W-1:0] slabs;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/slab_free_list_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Slab free-list allocator core
// LIFO free list of fixed-size slots threaded through a next-link memory,
// grown one slab at a time on demand or prefilled by an init operation.
// ----------------------------------------------------------------------------
// A free, a rejected free, an unused code or an allocate at the slab limit is
//   answered from idle; an allocate from a non-empty list reads the link, then
//   pops in ST_POP; one that grows a slab first pushes its slots in ST_GROW.
// Init pushes initial_slabs slabs in ST_INIT and reports no space when stopped
//   at the slab limit. One item at a time; input taken once idle.
// Reset clears head and slab count, restores config defaults; link memory kept.
`default_nettype none

module slab_free_list_allocator_core (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // input channel
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [sfla_pkg::OP_W-1:0]     in_operation_i,
  input  wire  [sfla_pkg::SLOT_W-1:0]   in_slot_index_i,
  // result channel
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [sfla_pkg::SLOT_W-1:0]   out_granted_slot_o,
  output logic [sfla_pkg::STAT_W-1:0]   out_status_o,
  output logic [sfla_pkg::SLAB_W-1:0]   out_slabs_made_o,
  // configuration write port
  input  wire                           cfg_we_i,
  input  wire  [sfla_pkg::CIDX_W-1:0]   cfg_index_i,
  input  wire  [sfla_pkg::CFG_W-1:0]    cfg_data_i
);

  import sfla_pkg::*;

  // FSM state codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_POP_RD = 3'd1;  // issue link read after a grow
  localparam logic [2:0] ST_POP    = 3'd2;  // link data back, pop the head
  localparam logic [2:0] ST_GROW   = 3'd3;  // push slots of a new slab
  localparam logic [2:0] ST_INIT   = 3'd4;  // prefill slabs
  localparam logic [2:0] ST_RESP   = 3'd5;  // result parked, output busy

  // config registers
  logic [SLAB_W-1:0] init_slabs_q;
  logic              validate_q;

  // list state
  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic              nonempty_q, nonempty_d;
  logic [SLAB_W-1:0] cnt_q, cnt_d;
  logic [SLAB_W-1:0] left_q, left_d;     // slabs still to prefill
  logic [K_W-1:0]    k_q, k_d;           // slot within the current slab

  // link memory: {end-of-list flag, next slot}
  logic [SLOT_W:0]   link_mem [NUM_SLOTS];
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_wa, mem_ra;
  logic [SLOT_W:0]   mem_wd;
  logic [SLOT_W:0]   rd_q;

  // results
  result_t           res, pend_q, pend_d, out_q;
  logic              res_v;
  logic              out_valid_q, out_load;
  result_t           out_d;
  logic              out_free;

  logic [EXT_W-1:0]  made_slots;
  logic [SLOT_W-1:0] push_slot;
  logic              free_bad;

  assign made_slots = EXT_W'(cnt_q) * EXT_W'(SLOTS_PER_SLAB);
  assign push_slot  = SLOT_W'(made_slots + EXT_W'(k_q));
  assign free_bad   = (EXT_W'(in_slot_index_i) >= EXT_W'(NUM_SLOTS)) ||
                      (validate_q && (EXT_W'(in_slot_index_i) >= made_slots));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign out_granted_slot_o = out_q.granted;
  assign out_status_o       = out_q.status;
  assign out_slabs_made_o   = out_q.slabs;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    nonempty_d = nonempty_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    k_d        = k_q;
    pend_d     = pend_q;
    mem_we     = 1'b0;
    mem_wa     = push_slot;
    mem_wd     = {~nonempty_q, head_q};  // a push onto an empty list marks the end
    mem_re     = 1'b0;
    mem_ra     = head_q;
    res_v      = 1'b0;
    res        = '0;
    out_load   = 1'b0;
    out_d      = pend_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_operation_i)
            OP_INIT: begin
              head_d     = '0;
              nonempty_d = 1'b0;
              cnt_d      = '0;
              k_d        = '0;
              if (init_slabs_q == '0) begin
                res_v = 1'b1;
              end else begin
                left_d  = init_slabs_q;
                state_d = ST_INIT;
              end
            end
            OP_ALLOC: begin
              if (nonempty_q) begin
                mem_re  = 1'b1;
                state_d = ST_POP;
              end else if (cnt_q >= SLAB_LIMIT) begin
                res_v      = 1'b1;
                res.status = STAT_NOSPACE;
              end else begin
                k_d     = '0;
                state_d = ST_GROW;
              end
            end
            OP_FREE: begin
              res_v = 1'b1;
              if (free_bad) begin
                res.status = STAT_INVALID;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = in_slot_index_i;
                head_d     = in_slot_index_i;
                nonempty_d = 1'b1;
              end
            end
            default: begin
              res_v = 1'b1;
            end
          endcase
        end
      end

      ST_GROW: begin
        mem_we     = 1'b1;
        head_d     = push_slot;
        nonempty_d = 1'b1;
        if (k_q == K_LAST) begin
          k_d     = '0;
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_POP_RD;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_POP_RD: begin
        mem_re  = 1'b1;
        state_d = ST_POP;
      end

      ST_POP: begin
        head_d      = rd_q[SLOT_W-1:0];
        if (rd_q[SLOT_W]) begin
          nonempty_d = 1'b0;
        end
        res_v       = 1'b1;
        res.granted = head_q;
      end

      ST_INIT: begin
        if ((k_q == '0) && (cnt_q >= SLAB_LIMIT)) begin
          // ran into the slab limit before the prefill finished
          res_v      = 1'b1;
          res.status = STAT_NOSPACE;
        end else begin
          mem_we     = 1'b1;
          head_d     = push_slot;
          nonempty_d = 1'b1;
          if (k_q == K_LAST) begin
            k_d    = '0;
            cnt_d  = cnt_q + 1'b1;
            left_d = left_q - 1'b1;
            if (left_q == SLAB_W'(1)) begin
              res_v = 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res.slabs = cnt_d;

    // a finished result goes straight out, or parks until the output frees
    if (res_v) begin
      if (out_free) begin
        out_load = 1'b1;
        out_d    = res;
        state_d  = ST_IDLE;
      end else begin
        pend_d  = res;
        state_d = ST_RESP;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      nonempty_q   <= 1'b0;
      cnt_q        <= '0;
      left_q       <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
      init_slabs_q <= INITIAL_SLABS_RST;
      validate_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      cnt_q      <= cnt_d;
      left_q     <= left_d;
      k_q        <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_INITIAL_SLABS: init_slabs_q <= cfg_data_i[SLAB_W-1:0];
          CFG_VALIDATE:      validate_q   <= cfg_data_i[0];
          default:           validate_q   <= validate_q;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // link memory, one access a cycle, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= link_mem[mem_ra];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sfla_checker.sv @@
// ----------------------------------------------------------------------------
// Slab free-list allocator checker
// Port-level properties of the allocator core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_stall_o,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire [sfla_pkg::SLOT_W-1:0]   out_granted_slot_o,
  input wire [sfla_pkg::STAT_W-1:0]   out_status_o,
  input wire [sfla_pkg::SLAB_W-1:0]   out_slabs_made_o,
  input wire                          cfg_we_i
);

  import sfla_pkg::*;

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_granted_slot_o)
      && $stable(out_status_o) && $stable(out_slabs_made_o))
    else $error("result changed while stalled");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_status_o == STAT_OK) || (out_status_o == STAT_NOSPACE)
      || (out_status_o == STAT_INVALID))
    else $error("undefined status code");

  // a failed operation hands out no slot
  a_fail_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != STAT_OK) |-> (out_granted_slot_o == '0))
    else $error("slot granted with error status");

  // slab count never passes the pool limit
  a_slab_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_slabs_made_o <= SLAB_LIMIT))
    else $error("slab count beyond limit");

  // register writes land only with nothing in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_valid_i && !in_stall_o && !out_valid_o)
    else $error("register write with a transfer in flight");

endmodule

bind slab_free_list_allocator_core sfla_checker u_sfla_checker (.*);

`default_nettype wire

@@ tb/sv/tb_slab_free_list_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Slab free-list allocator core testbench
// Drives init, allocate and free requests through the valid/stall input
// channel under bursty traffic and back-pressure. A shadow free list predicts
// every result, which is checked field by field as it leaves the core.
// ----------------------------------------------------------------------------
module tb_slab_free_list_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sfla_pkg::*;

  // the package names no code for the spare operation value
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT = 8000; // idle cycles before giving up
  localparam int unsigned HOLD_CYCLES    = 700;  // one long receiver hold-off
  localparam int unsigned HOLD_AFTER     = 400;  // results seen before it starts
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
  } slot_req_t;

  // --------------------------------------------------------------------------
  // DUT connections, all driven to known values from time zero
  // --------------------------------------------------------------------------
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation  = '0;
  logic [SLOT_W-1:0] in_slot_index = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [SLOT_W-1:0] out_granted_slot;
  logic [STAT_W-1:0] out_status;
  logic [SLAB_W-1:0] out_slabs_made;
  logic              cfg_we        = 1'b0;
  logic [CIDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]  cfg_data      = '0;

  slab_free_list_allocator_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_operation_i     (in_operation),
    .in_slot_index_i    (in_slot_index),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_granted_slot_o (out_granted_slot),
    .out_status_o       (out_status),
    .out_slabs_made_o   (out_slabs_made),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow of the allocator: register copies and the free list itself
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  shadow_initial_slabs = INITIAL_SLABS_RST;
  logic              shadow_validate      = 1'b0;

  logic [SLOT_W-1:0] fl_link   [NUM_SLOTS]; // next free slot below this one
  bit                fl_bottom [NUM_SLOTS]; // slot was pushed onto an empty list
  logic [SLOT_W-1:0] fl_head     = '0;
  bit                fl_nonempty = 1'b0;
  logic [SLAB_W-1:0] fl_slabs    = '0;

  slot_req_t         req_backlog [$];   // requests not yet offered to the core
  result_t           due_results [$];   // predicted results, oldest first

  int unsigned       mismatches   = 0;
  int unsigned       results_seen = 0;
  int unsigned       idle_cycles  = 0;
  logic              in_taken     = 1'b0; // input transfer at the last rising edge

  function automatic void push_slot(input int unsigned s);
    fl_link[s]   = fl_head;
    fl_bottom[s] = !fl_nonempty;
    fl_head      = SLOT_W'(s);
    fl_nonempty  = 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] pop_head();
    logic [SLOT_W-1:0] s;
    s = fl_head;
    if (fl_bottom[s]) fl_nonempty = 1'b0;
    fl_head = fl_link[s];
    return s;
  endfunction

  // adds the next slab, its slots pushed lowest first; fails at the slab cap
  function automatic bit grow_slab();
    int unsigned base, k;
    if (fl_slabs >= SLAB_LIMIT) return 1'b0;
    base = fl_slabs * SLOTS_PER_SLAB;
    for (k = 0; k < SLOTS_PER_SLAB; k++) push_slot(base + k);
    fl_slabs = fl_slabs + 1'b1;
    return 1'b1;
  endfunction

  function automatic result_t allocator_outcome(input logic [OP_W-1:0] op,
                                                input logic [SLOT_W-1:0] idx);
    result_t     r;
    int unsigned n;
    r.granted = '0;
    r.status  = STAT_OK;
    case (op)
      OP_INIT: begin
        fl_head     = '0;
        fl_nonempty = 1'b0;
        fl_slabs    = '0;
        // prefill stops at the slab cap and then reports no space
        for (n = 0; n < shadow_initial_slabs && r.status == STAT_OK; n++)
          if (!grow_slab()) r.status = STAT_NOSPACE;
      end
      OP_ALLOC: begin
        if (fl_nonempty) begin
          r.granted = pop_head();
        end else if (grow_slab()) begin
          r.granted = pop_head();
        end else begin
          r.status = STAT_NOSPACE;
        end
      end
      OP_FREE: begin
        if (32'(idx) >= NUM_SLOTS) begin
          r.status = STAT_INVALID;
        end else if (shadow_validate && 32'(idx) >= fl_slabs * SLOTS_PER_SLAB) begin
          r.status = STAT_INVALID;
        end else begin
          push_slot(idx); // a double free is pushed again, as the list does
        end
      end
      default: ; // spare code: nothing moves
    endcase
    r.slabs = fl_slabs;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued requests in bursts with random gaps. An offered
  // request is held until its transfer; valid never looks at stall.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : driver
    slot_req_t req;
    if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_backlog.size() != 0) begin
        req = req_backlog.pop_front();
        in_valid      <= 1'b1;
        in_operation  <= req.op;
        in_slot_index <= req.slot;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          // a quarter of bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: segments of random length, each with its own stall
  // density (none, light, half, heavy), plus one long hold-off so the core
  // fills up and stalls its input while the driver keeps offering.
  // --------------------------------------------------------------------------
  int unsigned seg_left  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin : stall_gen
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(1, 64);
        case ($urandom_range(0, 3))
          0:       stall_pct <= 0;
          1:       stall_pct <= 20;
          2:       stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        seg_left <= seg_left - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction, then
  // predicts for an input transfer on the same edge. Also feeds the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (!rst_ni) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result, granted_slot", out_granted_slot, 0);
        end else begin
          want = due_results.pop_front();
          if (out_granted_slot !== want.granted)
            flag_mismatch("granted_slot", out_granted_slot, want.granted);
          if (out_status !== want.status)
            flag_mismatch("status", out_status, want.status);
          if (out_slabs_made !== want.slabs)
            flag_mismatch("slabs_made", out_slabs_made, want.slabs);
        end
      end
      if (in_valid && !in_stall)
        due_results.push_back(allocator_outcome(in_operation, in_slot_index));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // no transfer for too long: the core has hung or lost a result
  initial begin : watchdog
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot);
    slot_req_t req;
    req.op   = op;
    req.slot = slot;
    req_backlog.push_back(req);
  endtask

  // random mix; slot indexes lean towards the low slots where slabs exist
  task automatic queue_mix(input int unsigned count, input int unsigned pct_init,
                           input int unsigned pct_alloc, input int unsigned pct_free);
    int unsigned       i, r;
    logic [SLOT_W-1:0] idx;
    for (i = 0; i < count; i++) begin
      r   = $urandom_range(0, 99);
      idx = ($urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, 31))
                                       : SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
      if (r < pct_init) queue_item(OP_INIT, idx);
      else if (r < pct_init + pct_alloc) queue_item(OP_ALLOC, idx);
      else if (r < pct_init + pct_alloc + pct_free) queue_item(OP_FREE, idx);
      else queue_item(OP_UNUSED, idx);
    end
  endtask

  // register writes only ever happen with the core idle
  task automatic write_cfg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_INITIAL_SLABS: shadow_initial_slabs = val;
      CFG_VALIDATE:      shadow_validate      = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int unsigned sub;
    logic [CFG_W-1:0] slabs_cfg;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // small pool, validation on: pop order, growth on empty, rejected and
    // double frees, spare code with the index field all ones
    write_cfg(CFG_INITIAL_SLABS, 11'd4);
    write_cfg(CFG_VALIDATE, 11'd1);
    @(posedge clk_i);
    queue_item(OP_INIT, '0);
    repeat (4) queue_item(OP_ALLOC, '0);
    queue_item(OP_ALLOC, '1);        // list empty: grows one slab
    queue_item(OP_FREE, 10'd2);
    queue_item(OP_FREE, 10'd9);      // beyond the slabs made
    queue_item(OP_FREE, '1);
    queue_item(OP_FREE, 10'd2);      // double free
    queue_item(OP_ALLOC, '0);
    queue_item(OP_ALLOC, '0);        // same slot handed out again
    queue_item(OP_UNUSED, '1);
    wait_drained();

    // empty prefill, validation off: any slot may be freed
    write_cfg(CFG_INITIAL_SLABS, 11'd0);
    write_cfg(CFG_VALIDATE, 11'd0);
    @(posedge clk_i);
    queue_item(OP_INIT, '1);
    queue_item(OP_FREE, '0);
    queue_item(OP_FREE, '1);
    repeat (3) queue_item(OP_ALLOC, '0);
    queue_item(OP_UNUSED, '0);
    wait_drained();

    // full pool prefilled exactly
    write_cfg(CFG_INITIAL_SLABS, CFG_W'(MAX_SLABS));
    @(posedge clk_i);
    queue_item(OP_INIT, '0);
    queue_item(OP_ALLOC, '0);
    wait_drained();

    // prefill asked beyond the cap: stops at the cap with no-space status
    write_cfg(CFG_INITIAL_SLABS, '1);
    write_cfg(CFG_VALIDATE, 11'd1);
    @(posedge clk_i);
    queue_item(OP_INIT, '0);
    wait_drained();

    // drain the full pool with allocates until the cap is hit and allocates
    // come back with no space
    write_cfg(CFG_VALIDATE, CFG_W'($urandom_range(0, 1)));
    @(posedge clk_i);
    queue_mix(1150, 0, 96, 2);
    wait_drained();

    // churn phases, each under its own register setting
    for (sub = 0; sub < 4; sub++) begin
      case (sub)
        0:       slabs_cfg = CFG_W'($urandom_range(2, 16));
        1:       slabs_cfg = '0;
        2:       slabs_cfg = CFG_W'($urandom_range(1, 8));
        default: slabs_cfg = CFG_W'(MAX_SLABS);
      endcase
      write_cfg(CFG_INITIAL_SLABS, slabs_cfg);
      write_cfg(CFG_VALIDATE, (sub == 1) ? 11'd0 : CFG_W'($urandom_range(0, 1)));
      @(posedge clk_i);
      queue_item(OP_INIT, '0);
      queue_mix(119, 3, 45, 45);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0)
      flag_mismatch("results still outstanding", due_results.size(), 0);

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
